/* rtl/core/ising_pkg.sv */
// ----------------------------------------------------------------------------
// ising_pkg
// Shared constants, types and helpers of the Ising Metropolis lattice block.
// ----------------------------------------------------------------------------
`default_nettype none

package ising_pkg;

  localparam int LATTICE_SIDE = 128;
  localparam int ROW_W        = $clog2(LATTICE_SIDE);
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;

  localparam int COORD_W  = 7;
  localparam int DRAW_W   = 16;
  localparam int THR_W    = 17;
  localparam int DE_W     = 5;
  localparam int MAG_W    = 16;
  localparam int ENERGY_W = 17;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [THR_W-1:0]    THR_FOUR_RST  = THR_W'(1200);
  localparam logic [THR_W-1:0]    THR_EIGHT_RST = THR_W'(22);
  localparam logic [MAG_W-1:0]    MAG_RST       = MAG_W'(SITE_COUNT);
  localparam logic [ENERGY_W-1:0] ENERGY_RST    = ENERGY_W'(-2 * SITE_COUNT);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_THR_FOUR  = 1'b0,
    REG_THR_EIGHT = 1'b1
  } cfg_reg_t;

  // item kinds carried in tuser
  typedef enum logic [0:0] {
    FUNC_UPDATE = 1'b0,
    FUNC_LOAD   = 1'b1
  } func_t;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_t;

  typedef struct packed {
    logic                   change;
    logic signed [DE_W-1:0] de;
  } decision_t;

  function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] k);
    return (k == ROW_W'(LATTICE_SIDE - 1)) ? '0 : k + ROW_W'(1);
  endfunction

  function automatic logic [ROW_W-1:0] wrap_dec(input logic [ROW_W-1:0] k);
    return (k == '0) ? ROW_W'(LATTICE_SIDE - 1) : k - ROW_W'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ising_metropolis_lattice.sv */
// ----------------------------------------------------------------------------
// ising_metropolis_lattice
// Square spin lattice with wrap-around edges, Metropolis updates and loads,
// running magnetization and energy sums.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes ST_CENTER and ST_DECIDE, where out_tvalid is
//   registered once the output is free; only then is a new item taken. The order
//   is set by the two-read-port lattice memory: neighbour rows, then the own row,
//   then decide and write back. Reset: synchronous; a clearing sweep writes each
//   of the LATTICE_SIDE (128) rows to +1 while in_tready stays low; config writes are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_lattice (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // config write port
  input  wire logic                                 cfg_we,
  input  wire ising_pkg::cfg_reg_t                  cfg_index,
  input  wire logic [ising_pkg::THR_W-1:0]          cfg_data,
  // input beats
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // site_row[6:0], site_col[13:7], random_draw[29:14], load_spin[30], zero[31]
  input  wire logic [ising_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func[0]
  input  wire logic                                 in_tuser,
  // result beats
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // flipped[0], spin_now[1], energy_change[6:2], magnetization[22:7],
  // total_energy[39:23]
  output logic [ising_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import ising_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_CENTER = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // lattice: one row per entry
  logic [LATTICE_SIDE-1:0] lattice_mem [LATTICE_SIDE];
  logic [LATTICE_SIDE-1:0] q_a_r, q_b_r;
  logic                    rd_a_en, rd_b_en;
  logic [ROW_W-1:0]        rd_a_addr, rd_b_addr;
  logic                    mem_we;
  logic [ROW_W-1:0]        mem_waddr;
  logic [LATTICE_SIDE-1:0] mem_wdata;

  logic [ROW_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [THR_W-1:0] thr_four_r, thr_eight_r;

  // input unpack
  logic [COORD_W-1:0] in_row, in_col;
  logic [DRAW_W-1:0]  in_draw;
  logic               in_load;
  logic               accept;
  logic [ROW_W-1:0]   in_row_t;

  // item registers
  logic [ROW_W-1:0]  row_r, col_r;
  logic              range_r;
  func_t             func_r;
  logic [DRAW_W-1:0] draw_r;
  logic              load_r;
  logic              up_bit_r, dn_bit_r;

  // decision
  logic             spin_self;
  nbr_t             nbr;
  decision_t        dec;
  logic             flip;
  logic             fire;
  logic [LATTICE_SIDE-1:0] row_new;

  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   flipped_r;
  logic                   spin_now_r;
  logic signed [DE_W-1:0] de_r;

  assign in_row  = in_tdata[6:0];
  assign in_col  = in_tdata[13:7];
  assign in_draw = in_tdata[29:14];
  assign in_load = in_tdata[30];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign in_row_t  = ROW_W'(in_row);

  // ---- memory ports ----
  // neighbour rows are read at the accept edge, own row in ST_CENTER
  assign rd_a_en   = accept | (state_r == ST_CENTER);
  assign rd_a_addr = accept ? wrap_inc(in_row_t) : row_r;
  assign rd_b_en   = accept;
  assign rd_b_addr = wrap_dec(in_row_t);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_a_en) begin
      q_a_r <= lattice_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      q_b_r <= lattice_mem[rd_b_addr];
    end
  end

  // ---- decision on the own row ----
  assign spin_self = q_a_r[col_r];
  assign nbr.up    = up_bit_r;
  assign nbr.dn    = dn_bit_r;
  assign nbr.lf    = q_a_r[wrap_dec(col_r)];
  assign nbr.rt    = q_a_r[wrap_inc(col_r)];

  ising_flip_decide u_decide (
    .spin_self (spin_self),
    .nbr       (nbr),
    .func      (func_r),
    .load_spin (load_r),
    .draw      (draw_r),
    .thr_four  (thr_four_r),
    .thr_eight (thr_eight_r),
    .dec       (dec)
  );

  assign flip = range_r & dec.change;
  assign fire = (state_r == ST_DECIDE) & (~out_valid_r | out_tready);

  always_comb begin
    row_new        = q_a_r;
    row_new[col_r] = spin_self ^ flip;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_r;
    mem_wdata = row_new;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '1;
    end else if (fire && flip) begin
      mem_we = 1'b1;
    end
  end

  // running sums: a flip of s changes magnetization by -2s and energy by dE
  always_comb begin
    mag_nxt    = mag_r;
    energy_nxt = energy_r;
    if (fire && flip) begin
      mag_nxt    = spin_self ? mag_r - MAG_W'(2) : mag_r + MAG_W'(2);
      energy_nxt = energy_r + ENERGY_W'(dec.de);
    end
  end

  // ---- control ----
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
        if (clr_cnt_r == ROW_W'(LATTICE_SIDE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CENTER;
        end
      end
      ST_CENTER: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r & ~out_tready) | fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      mag_r       <= MAG_RST;
      energy_r    <= ENERGY_RST;
      thr_four_r  <= THR_FOUR_RST;
      thr_eight_r <= THR_EIGHT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mag_r       <= mag_nxt;
      energy_r    <= energy_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THR_FOUR:  thr_four_r  <= cfg_data;
          REG_THR_EIGHT: thr_eight_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r   <= in_row_t;
      col_r   <= ROW_W'(in_col);
      range_r <= (32'(in_row) < LATTICE_SIDE) && (32'(in_col) < LATTICE_SIDE);
      func_r  <= func_t'(in_tuser);
      draw_r  <= in_draw;
      load_r  <= in_load;
    end
    if (state_r == ST_CENTER) begin
      up_bit_r <= q_a_r[col_r];
      dn_bit_r <= q_b_r[col_r];
    end
    if (fire) begin
      flipped_r  <= flip;
      spin_now_r <= range_r & (spin_self ^ flip);
      de_r       <= range_r ? dec.de : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_TDATA_W'({energy_r, mag_r, de_r, spin_now_r, flipped_r})};

endmodule

`default_nettype wire

/* rtl/core/ising_flip_decide.sv */
// ----------------------------------------------------------------------------
// ising_flip_decide
// Energy change of one site and the Metropolis accept / load decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_flip_decide (
  input  wire logic                            spin_self,
  input  wire ising_pkg::nbr_t                 nbr,
  input  wire ising_pkg::func_t                func,
  input  wire logic                            load_spin,
  input  wire logic [ising_pkg::DRAW_W-1:0]    draw,
  input  wire logic [ising_pkg::THR_W-1:0]     thr_four,
  input  wire logic [ising_pkg::THR_W-1:0]     thr_eight,
  output ising_pkg::decision_t                 dec
);
  import ising_pkg::*;

  logic [2:0]             up_count;
  logic signed [DE_W-1:0] around2;
  logic signed [DE_W-1:0] de;
  logic [THR_W-1:0]       draw_ext;
  logic                   change;

  // number of +1 neighbours, 0..4
  assign up_count = 3'(nbr.up) + 3'(nbr.dn) + 3'(nbr.lf) + 3'(nbr.rt);

  // 2 * neighbour sum = 4*n - 8
  assign around2 = $signed({up_count, 2'b00}) - DE_W'(8);
  assign de      = spin_self ? around2 : -around2;

  assign draw_ext = {1'b0, draw};

  always_comb begin
    priority if (func == FUNC_LOAD) begin
      change = (spin_self != load_spin);
    end else if (de <= $signed(DE_W'(0))) begin
      change = 1'b1;
    end else if (de == $signed(DE_W'(4))) begin
      change = (draw_ext < thr_four);
    end else if (de == $signed(DE_W'(8))) begin
      change = (draw_ext < thr_eight);
    end else begin
      change = 1'b0;
    end
  end

  assign dec.change = change;
  assign dec.de     = de;

endmodule

`default_nettype wire

/* rtl/core/ising_checker.sv */
// ----------------------------------------------------------------------------
// ising_checker
// Port-level checks of the Ising lattice block, bound to ising_metropolis_lattice.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // a result beat that is not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // an accepted item keeps the input closed while the lattice is accessed
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input reopened during lattice access");

  // dE is always a multiple of four
  a_de_mult4: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:2] == 2'b00))
    else $error("energy change not a multiple of four");

  // magnetization of an even lattice stays even
  a_mag_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("odd magnetization");

  // four neighbours bound dE to -8..8
  a_de_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[6:2]) >= -5'sd8) &&
      ($signed(out_tdata[6:2]) <= 5'sd8))
    else $error("energy change out of range");

endmodule

bind ising_metropolis_lattice ising_checker u_ising_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
